[hdl/rfrp_pkg.sv]
// Shared constants for the RFID reader frame parser.
// Command codes, frame format values and channel widths.
// No dependencies.
package rfrp_pkg;

  localparam int FRAME_MAX = 28;
  localparam int CNT_W     = $clog2(FRAME_MAX + 1);

  // input channel
  localparam int CMD_W     = 3;
  localparam int IN_DATA_W = 48;

  // result channel: 218 bits of fields padded to whole bytes
  localparam int OUT_DATA_W = 224;

  localparam logic [CMD_W-1:0] CMD_BYTE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE_ERR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UART_ERR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE_ID  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  localparam logic REG_GAP_LIMIT = 1'b0;
  localparam logic REG_READER_ADDR = 1'b1;

  localparam logic [15:0] GAP_LIMIT_RST = 16'd100;

  localparam logic [7:0] XOR_GOOD   = 8'hFF;
  localparam logic [7:0] SOF_A      = 8'd1;
  localparam logic [7:0] SOF_B      = 8'd4;
  localparam logic [7:0] SUB_A1     = 8'hA1;
  localparam logic [7:0] SUB_TWO    = 8'd2;
  localparam logic [7:0] SUB_FOUR   = 8'd4;
  localparam logic [7:0] LEN_8      = 8'd8;
  localparam logic [7:0] LEN_12     = 8'd12;
  localparam logic [7:0] LEN_22     = 8'd22;
  localparam logic [7:0] LEN_28     = 8'd28;

  // byte positions checked or kept from a frame
  localparam logic [CNT_W-1:0] POS_KIND   = 5'd0;
  localparam logic [CNT_W-1:0] POS_LEN    = 5'd1;
  localparam logic [CNT_W-1:0] POS_SUB    = 5'd2;
  localparam logic [CNT_W-1:0] POS_ADDR   = 5'd3;
  localparam logic [CNT_W-1:0] POS_STATUS = 5'd4;
  localparam logic [CNT_W-1:0] POS_UID0   = 5'd7;
  localparam logic [CNT_W-1:0] POS_UID1   = 5'd8;
  localparam logic [CNT_W-1:0] POS_UID2   = 5'd9;
  localparam logic [CNT_W-1:0] POS_UID3   = 5'd10;

  function automatic logic is_sof(input logic [7:0] b);
    return (b == SOF_A) || (b == SOF_B);
  endfunction

endpackage

[hdl/rfid_reader_frame_parser.sv]
// RFID reader frame parser: byte stream framing, checksum, tag id extraction, counters.
// Depends on rfrp_pkg.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready  | tuser cmd, tdata byte/time/error
//  out_    | out | out_tvalid / out_tready| tdata result fields
//  cfg_    | in  | cfg_we                 | cfg_addr, cfg_wdata
//
// One beat in, one beat out; a beat can be taken every cycle while the result is not stalled.
// Path: input register, then parse logic into the result register.
// Frame state updates at the same edge the result register loads.
// rst_n is synchronous; counters, frame position and pending id clear on reset.
// A stalled result holds; the input register takes one more beat, then in_tready drops.
module rfid_reader_frame_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // lsb up: data_byte[7:0], now_ms[39:8], error_code[47:40]
  input  logic [rfrp_pkg::IN_DATA_W-1:0]   in_tdata,
  // cmd[2:0]
  input  logic [rfrp_pkg::CMD_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // lsb up: read_ok[0], read_uid[32:1], id_pending[33], good_frames[65:34],
  // bad_frames[97:66], tags_seen[129:98], bytes_seen[161:130], status_byte[169:162],
  // newest_uid[201:170], newest_byte[209:202], newest_error[217:210], zero pad
  output logic [rfrp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [15:0]                      cfg_wdata
);
  import rfrp_pkg::*;

  // config
  logic [15:0] gap_limit_r;
  logic [7:0]  reader_addr_r;

  // input register
  logic                 stg_valid_r;
  logic [CMD_W-1:0]     stg_cmd_r;
  logic [7:0]           stg_byte_r;
  logic [31:0]          stg_now_r;
  logic [7:0]           stg_err_r;
  logic                 stg_fire;

  // frame and status state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] held_uid_r, held_uid_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;
  logic [31:0] tags_r, tags_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  logic [7:0]  rstat_r, rstat_nxt;
  logic [31:0] new_uid_r, new_uid_nxt;
  logic [7:0]  new_byte_r, new_byte_nxt;
  logic [7:0]  new_err_r, new_err_nxt;

  // kept frame bytes
  logic [7:0]  kind_r, len_r, sub_r, fstat_r;
  logic [31:0] fuid_r;

  logic                 wr_en;
  logic [CNT_W-1:0]     wr_pos;
  logic                 rd_ok;
  logic [31:0]          rd_uid;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign stg_fire  = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || stg_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r   <= GAP_LIMIT_RST;
      reader_addr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GAP_LIMIT:   gap_limit_r   <= cfg_wdata;
        REG_READER_ADDR: reader_addr_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      stg_cmd_r  <= in_tuser;
      stg_byte_r <= in_tdata[7:0];
      stg_now_r  <= in_tdata[39:8];
      stg_err_r  <= in_tdata[47:40];
    end
  end

  always_comb begin
    logic [31:0]      gap;
    logic [CNT_W-1:0] pos0;
    logic             put;
    logic             len_ok;
    logic [7:0]       xor_new;
    logic             tag_form;

    gap      = stg_now_r - last_time_r;
    pos0     = cnt_r;
    put      = 1'b0;
    len_ok   = 1'b0;
    xor_new  = '0;
    tag_form = 1'b0;

    cnt_nxt       = cnt_r;
    xor_nxt       = xor_r;
    last_time_nxt = last_time_r;
    pend_nxt      = pend_r;
    held_uid_nxt  = held_uid_r;
    good_nxt      = good_r;
    bad_nxt       = bad_r;
    tags_nxt      = tags_r;
    bytes_nxt     = bytes_r;
    rstat_nxt     = rstat_r;
    new_uid_nxt   = new_uid_r;
    new_byte_nxt  = new_byte_r;
    new_err_nxt   = new_err_r;
    wr_en         = 1'b0;
    wr_pos        = '0;
    rd_ok         = 1'b0;
    rd_uid        = '0;

    case (stg_cmd_r)
      CMD_BYTE: begin
        bytes_nxt     = bytes_r + 32'd1;
        new_byte_nxt  = stg_byte_r;
        last_time_nxt = stg_now_r;
        if (gap > {16'd0, gap_limit_r}) pos0 = '0;
        len_ok = (stg_byte_r == LEN_8) || (stg_byte_r == LEN_12) ||
                 (stg_byte_r == LEN_22) || (stg_byte_r == LEN_28);
        cnt_nxt = pos0;
        if (pos0 == POS_KIND) begin
          put = is_sof(stg_byte_r);
        end else if (pos0 == POS_LEN && !len_ok) begin
          // bad length: count it, resync if this byte is a start byte
          bad_nxt = bad_r + 32'd1;
          cnt_nxt = '0;
          if (is_sof(stg_byte_r)) begin
            pos0 = POS_KIND;
            put  = 1'b1;
          end
        end else if (pos0 == POS_ADDR && stg_byte_r != reader_addr_r) begin
          bad_nxt = bad_r + 32'd1;
          cnt_nxt = '0;
        end else begin
          put = 1'b1;
        end

        if (put) begin
          wr_en   = 1'b1;
          wr_pos  = pos0;
          xor_new = (pos0 == '0) ? stg_byte_r : (xor_r ^ stg_byte_r);
          xor_nxt = xor_new;
          cnt_nxt = pos0 + CNT_W'(1);
          // frame end; the kept bytes used below are all earlier than the last one
          if (pos0 >= POS_SUB && {3'd0, pos0 + CNT_W'(1)} == len_r) begin
            cnt_nxt = '0;
            if (xor_new != XOR_GOOD) begin
              bad_nxt = bad_r + 32'd1;
            end else begin
              good_nxt  = good_r + 32'd1;
              rstat_nxt = fstat_r;
              tag_form  = (kind_r == SOF_A && sub_r == SUB_A1   && len_r == LEN_12) ||
                          (kind_r == SOF_B && sub_r == SUB_TWO  && len_r == LEN_12) ||
                          (kind_r == SOF_B && sub_r == SUB_FOUR && len_r == LEN_28);
              if (fstat_r == 8'd0 && tag_form) begin
                new_uid_nxt = fuid_r;
                tags_nxt    = tags_r + 32'd1;
                if (!pend_r) begin
                  held_uid_nxt = fuid_r;
                  pend_nxt     = 1'b1;
                end
              end
            end
          end
        end
      end
      CMD_BYTE_ERR: begin
        bytes_nxt    = bytes_r + 32'd1;
        new_byte_nxt = stg_byte_r;
        new_err_nxt  = stg_err_r;
      end
      CMD_UART_ERR: begin
        new_err_nxt  = stg_err_r;
        held_uid_nxt = '0;
        pend_nxt     = 1'b0;
        cnt_nxt      = '0;
        xor_nxt      = '0;
      end
      CMD_TAKE_ID: begin
        if (pend_r) begin
          rd_ok    = 1'b1;
          rd_uid   = held_uid_r;
          pend_nxt = 1'b0;
        end
      end
      CMD_CLEAR: begin
        held_uid_nxt = '0;
        pend_nxt     = 1'b0;
        cnt_nxt      = '0;
        xor_nxt      = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      xor_r       <= '0;
      last_time_r <= '0;
      pend_r      <= 1'b0;
      held_uid_r  <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      tags_r      <= '0;
      bytes_r     <= '0;
      rstat_r     <= '0;
      new_uid_r   <= '0;
      new_byte_r  <= '0;
      new_err_r   <= '0;
    end else if (stg_fire) begin
      cnt_r       <= cnt_nxt;
      xor_r       <= xor_nxt;
      last_time_r <= last_time_nxt;
      pend_r      <= pend_nxt;
      held_uid_r  <= held_uid_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      tags_r      <= tags_nxt;
      bytes_r     <= bytes_nxt;
      rstat_r     <= rstat_nxt;
      new_uid_r   <= new_uid_nxt;
      new_byte_r  <= new_byte_nxt;
      new_err_r   <= new_err_nxt;
    end
  end

  // only the frame bytes that are ever looked at are kept
  always_ff @(posedge clk) begin
    if (stg_fire && wr_en) begin
      case (wr_pos)
        POS_KIND:   kind_r        <= stg_byte_r;
        POS_LEN:    len_r         <= stg_byte_r;
        POS_SUB:    sub_r         <= stg_byte_r;
        POS_STATUS: fstat_r       <= stg_byte_r;
        POS_UID0:   fuid_r[31:24] <= stg_byte_r;
        POS_UID1:   fuid_r[23:16] <= stg_byte_r;
        POS_UID2:   fuid_r[15:8]  <= stg_byte_r;
        POS_UID3:   fuid_r[7:0]   <= stg_byte_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (stg_fire) begin
      out_data_r <= {6'd0, new_err_nxt, new_byte_nxt, new_uid_nxt, rstat_nxt,
                     bytes_nxt, tags_nxt, bad_nxt, good_nxt, pend_nxt, rd_uid, rd_ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a take that succeeds always leaves nothing pending
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> !out_tdata[33])
    else $error("read_ok with id still pending");

  // frame position never runs past the longest frame
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAME_MAX))
    else $error("frame position out of range");

  // a partial frame always began with a start byte
  a_sof_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (kind_r == SOF_A || kind_r == SOF_B))
    else $error("partial frame without start byte");

  // state moves only when a beat is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_fire |=> ($stable(good_r) && $stable(bytes_r) && $stable(pend_r)))
    else $error("state changed without a beat");

endmodule
